>>> rtl/thc_pkg.sv
// ----------------------------------------------------------------------------
// Triangle classifier package
// Field widths and the side-band record that travels with each request.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int SIDE_IN_W = 12;
    localparam int PERIM_W   = 14;
    localparam int AREA_W    = 25;

    typedef struct packed {
        logic               ok;
        logic [PERIM_W-1:0] perimeter;
        logic               isosceles;
    } thc_info_t;

endpackage

>>> rtl/triangle_heron_classifier.sv
// ----------------------------------------------------------------------------
// Heron triangle classifier
// Validates three side lengths and returns perimeter, four times the area
// and an isosceles flag for each request.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one result per request
// in order. A request passes through the checks and the two multiplier
// stages that build the radicand, a chain of square-root cells with one cell
// per root bit, and the output register. When the output is stalled the
// whole pipeline holds and the input stops taking requests.
module triangle_heron_classifier #(
    parameter int SIDE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // side_a[11:0], side_b[23:12], side_c[35:24], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // perimeter[13:0], area_quarters[38:14], is_isosceles[39]
    output logic        m_tuser    // valid_res
);

    localparam int SW     = thc_pkg::SIDE_IN_W;
    localparam int AW     = thc_pkg::AREA_W;
    localparam int ROOT_W = 2 * SIDE_BITS + 3;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic                en;
    logic [SIDE_BITS-1:0] side_a, side_b, side_c;

    logic                vld_c  [0:ROOT_W];
    thc_pkg::thc_info_t  info_c [0:ROOT_W];
    logic [RAD_W-1:0]    rad_c  [0:ROOT_W];
    logic [REM_W-1:0]    rem_c  [0:ROOT_W];
    logic [ROOT_W-1:0]   root_c [0:ROOT_W];

    thc_pkg::thc_info_t  last_info;
    logic [AW-1:0]       area_next;
    logic [39:0]         tdata_next;

    logic                m_tvalid_reg;
    logic [39:0]         m_tdata_reg;
    logic                m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    assign side_a = SIDE_BITS'(s_tdata[SW-1:0]);
    assign side_b = SIDE_BITS'(s_tdata[2*SW-1:SW]);
    assign side_c = SIDE_BITS'(s_tdata[3*SW-1:2*SW]);

    thc_front #(
        .SIDE_BITS(SIDE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .side_a  (side_a),
        .side_b  (side_b),
        .side_c  (side_c),
        .out_vld (vld_c[0]),
        .out_info(info_c[0]),
        .out_rad (rad_c[0])
    );

    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
        thc_sqrt_cell #(
            .ROOT_W(ROOT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_vld  (vld_c[i]),
            .in_info (info_c[i]),
            .in_rad  (rad_c[i]),
            .in_rem  (rem_c[i]),
            .in_root (root_c[i]),
            .out_vld (vld_c[i+1]),
            .out_info(info_c[i+1]),
            .out_rad (rad_c[i+1]),
            .out_rem (rem_c[i+1]),
            .out_root(root_c[i+1])
        );
    end

    always_comb begin
        last_info  = info_c[ROOT_W];
        area_next  = last_info.ok ? AW'(root_c[ROOT_W]) : '0;
        tdata_next = {last_info.isosceles, area_next, last_info.perimeter};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_c[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= last_info.ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("Result for a rejected triangle is not all zero.");

    a_iso_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[39]) |-> m_tuser)
        else $error("Isosceles flag set on a rejected triangle.");

    a_perim_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((SIDE_BITS > 12) || (m_tdata[13:0] != '0)))
        else $error("Valid triangle returned with a zero perimeter.");
`endif

endmodule

>>> rtl/thc_front.sv
// ----------------------------------------------------------------------------
// Triangle classifier front end
// Checks the sides, forms the perimeter and builds the Heron radicand over
// three pipeline stages.
// ----------------------------------------------------------------------------
module thc_front #(
    parameter int SIDE_BITS = 12,
    localparam int P_W   = SIDE_BITS + 2,
    localparam int D_W   = SIDE_BITS + 1,
    localparam int M1_W  = P_W + D_W,
    localparam int M2_W  = 2 * D_W,
    localparam int RAD_W = 2 * M1_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [SIDE_BITS-1:0]   side_a,
    input  logic [SIDE_BITS-1:0]   side_b,
    input  logic [SIDE_BITS-1:0]   side_c,
    output logic                   out_vld,
    output thc_pkg::thc_info_t     out_info,
    output logic [RAD_W-1:0]       out_rad
);

    localparam int PW = thc_pkg::PERIM_W;

    logic [D_W-1:0]      sab, sbc, sac;
    logic                ok_next;
    logic [P_W-1:0]      p_next;
    logic [D_W-1:0]      d1_next, d2_next, d3_next;
    thc_pkg::thc_info_t  info1_next;
    logic [M1_W-1:0]     m1_next;
    logic [M2_W-1:0]     m2_next;
    logic [RAD_W-1:0]    rad_next;

    logic                v1_reg, v2_reg, v3_reg;
    thc_pkg::thc_info_t  info1_reg, info2_reg, info3_reg;
    logic [P_W-1:0]      p_reg;
    logic [D_W-1:0]      d1_reg, d2_reg, d3_reg;
    logic [M1_W-1:0]     m1_reg;
    logic [M2_W-1:0]     m2_reg;
    logic [RAD_W-1:0]    rad_reg;

    always_comb begin
        sab     = D_W'(side_a) + D_W'(side_b);
        sbc     = D_W'(side_b) + D_W'(side_c);
        sac     = D_W'(side_a) + D_W'(side_c);
        ok_next = (side_a != '0) && (side_b != '0) && (side_c != '0) &&
                  (D_W'(side_a) < sbc) && (D_W'(side_b) < sac) &&
                  (D_W'(side_c) < sab);
        p_next  = P_W'(sab) + P_W'(side_c);
        d1_next = sbc - D_W'(side_a);
        d2_next = sac - D_W'(side_b);
        d3_next = sab - D_W'(side_c);
        info1_next.ok        = ok_next;
        info1_next.perimeter = ok_next ? PW'(p_next) : '0;
        info1_next.isosceles = ok_next && ((side_a == side_b) || (side_b == side_c) ||
                                           (side_c == side_a));
        m1_next  = M1_W'(p_reg) * M1_W'(d1_reg);
        m2_next  = M2_W'(d2_reg) * M2_W'(d3_reg);
        rad_next = RAD_W'(m1_reg) * RAD_W'(m2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            info1_reg <= info1_next;
            p_reg     <= p_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            d3_reg    <= d3_next;
            info2_reg <= info1_reg;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            info3_reg <= info2_reg;
            rad_reg   <= rad_next;
        end
    end

    assign out_vld  = v3_reg;
    assign out_info = info3_reg;
    assign out_rad  = rad_reg;

endmodule

>>> rtl/thc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square-root cell
// One digit-recurrence step: takes the next two radicand bits and settles one
// root bit, then hands the request to the next cell.
// ----------------------------------------------------------------------------
module thc_sqrt_cell #(
    parameter int ROOT_W = 27,
    localparam int RAD_W = 2 * ROOT_W,
    localparam int REM_W = ROOT_W + 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  thc_pkg::thc_info_t    in_info,
    input  logic [RAD_W-1:0]      in_rad,
    input  logic [REM_W-1:0]      in_rem,
    input  logic [ROOT_W-1:0]     in_root,
    output logic                  out_vld,
    output thc_pkg::thc_info_t    out_info,
    output logic [RAD_W-1:0]      out_rad,
    output logic [REM_W-1:0]      out_rem,
    output logic [ROOT_W-1:0]     out_root
);

    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                take;
    logic [REM_W-1:0]    rem_next;
    logic [ROOT_W-1:0]   root_next;
    logic [RAD_W-1:0]    rad_next;

    logic                vld_reg;
    thc_pkg::thc_info_t  info_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    always_comb begin
        rem_sh    = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
        trial     = {in_root, 2'b01};
        take      = rem_sh >= trial;
        rem_next  = take ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[ROOT_W-2:0], take};
        rad_next  = {in_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            info_reg <= in_info;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_info = info_reg;
    assign out_rad  = rad_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;

endmodule
